/* sv/ggsa_pkg.sv */
// Shared constants for the Gaussian grid splat accumulator.
package ggsa_pkg;

   // Default sizes of the grid, the radius limit and the weight table.
   localparam int GRID_W_DEF       = 256;
   localparam int GRID_H_DEF       = 256;
   localparam int MAX_RADIUS_DEF   = 7;
   localparam int WEIGHT_TABLE_DEF = 256;

   // Configuration register indexes.
   localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE     = 3'd2;
   localparam logic [2:0] REG_RADIUS_CELLS  = 3'd3;
   localparam logic [2:0] REG_INV_CUTOFF_SQ = 3'd4;
   localparam logic [2:0] REG_GRID_WIDTH    = 3'd5;
   localparam logic [2:0] REG_GRID_HEIGHT   = 3'd6;

   // Command codes carried in the request tuser bit.
   localparam logic CMD_SPLAT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Register reset values.
   localparam logic [31:0] RST_CELL_SIZE = 32'd65536;
   localparam logic [2:0]  RST_RADIUS    = 3'd3;
   localparam logic [31:0] RST_INV_CUT   = 32'd65536;
   localparam logic [8:0]  RST_GRID_DIM  = 9'd256;

endpackage

/* sv/gaussian_grid_splat_accumulator.sv */
// Gaussian grid splat accumulator: per-cell weighted sums built by a sequencer
// around one shared multiplier and a bit-serial divider.
//
// Request channel (req_*): tuser is the command, 0 splat a point, 1 read a cell.
// A splat adds value*weight and weight to every in-grid cell within the radius of
// the point's home cell; it returns nothing. A read returns one transaction on the
// response channel (rsp_*) with the cell's two sums and a valid flag. Configuration
// (csr_*) is always ready; users write it while the block is idle (not checked).
//
// After reset a clearing pass zeroes both accumulator memories, one entry a
// cycle, all GRID_W*GRID_H entries; requests are held off meanwhile.
// A read registers the cell address, then the memory data, then loads the response.
// A splat divides each axis offset by the cell size in the bit-serial divider,
// one quotient bit a cycle, then steps both doubled offsets to the lowest
// neighbor row and column and visits each of the (2r+1)^2 neighborhood cells:
// one outside the grid or beyond the cutoff on either axis is skipped, else it
// takes squares, exponent products and read-modify-write on the one multiplier.
// One request is worked on at a time. A response waits in its register while
// the receiver stalls and the block takes the next request meanwhile; a read
// that finishes before the previous response is taken waits for it.
module gaussian_grid_splat_accumulator
   import ggsa_pkg::*;
#(
   parameter int GRID_W       = GRID_W_DEF,
   parameter int GRID_H       = GRID_H_DEF,
   parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
   parameter int WEIGHT_TABLE = WEIGHT_TABLE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0], pos_y[63:32], sample_value[95:64], cell_x[103:96], cell_y[111:104]
   input  logic [111:0] req_tdata,
   // cmd[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cell_sum[63:0], cell_weight[111:64]
   output logic [111:0] rsp_tdata,
   // cell_valid[0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = $clog2(WEIGHT_TABLE);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_SET  = 4'd3;
   localparam logic [3:0] S_CELL = 4'd4;
   localparam logic [3:0] S_M1   = 4'd5;
   localparam logic [3:0] S_M2   = 4'd6;
   localparam logic [3:0] S_M3   = 4'd7;
   localparam logic [3:0] S_M4   = 4'd8;
   localparam logic [3:0] S_M5   = 4'd9;
   localparam logic [3:0] S_RD   = 4'd10;
   localparam logic [3:0] S_ACC  = 4'd11;
   localparam logic [3:0] S_RQ   = 4'd12;
   localparam logic [3:0] S_RO   = 4'd13;

   typedef logic [15:0] wtab_type [WEIGHT_TABLE];

   // Division by the Taylor term index, one constant divisor per index.
   function automatic longint div_k(longint v, int k);
      case (k)
         1:       div_k = v / 1;
         2:       div_k = v / 2;
         3:       div_k = v / 3;
         4:       div_k = v / 4;
         5:       div_k = v / 5;
         6:       div_k = v / 6;
         7:       div_k = v / 7;
         8:       div_k = v / 8;
         9:       div_k = v / 9;
         10:      div_k = v / 10;
         11:      div_k = v / 11;
         12:      div_k = v / 12;
         13:      div_k = v / 13;
         14:      div_k = v / 14;
         15:      div_k = v / 15;
         16:      div_k = v / 16;
         17:      div_k = v / 17;
         18:      div_k = v / 18;
         19:      div_k = v / 19;
         default: div_k = v / 20;
      endcase
   endfunction

   // Weight table exp(-16*i/WEIGHT_TABLE) in Q0.16, built at elaboration.
   function automatic wtab_type build_wtab();
      wtab_type          t;
      longint            term;
      longint            acc;
      longint unsigned   r;
      for (int i = 0; i < WEIGHT_TABLE; i++) begin
         term = longint'(64'd1 << 31);
         acc  = term;
         for (int k = 1; k <= 20; k++) begin
            term = div_k((term * longint'(i)) / WEIGHT_TABLE, k);
            acc  = (k % 2 == 1) ? acc - term : acc + term;
         end
         r = (acc < 0) ? 64'd0 : longint'(acc);
         for (int s = 0; s < 4; s++) begin
            r = (r * r + (64'd1 << 30)) >> 31;
         end
         r = (r + (64'd1 << 14)) >> 15;
         t[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
      end
      return t;
   endfunction

   localparam wtab_type WTAB = build_wtab();

   // Configuration registers.
   logic [31:0] org_x_ff, org_y_ff, cell_size_ff, inv_ff;
   logic [2:0]  radius_ff;
   logic [8:0]  gw_ff, gh_ff;

   // Sequencer and per-item registers.
   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0] val_ff, val_in;
   logic [31:0]        cs_ff, cs_in;
   logic [2:0]         r_ff, r_in;
   logic [31:0]        div_rem_ff, div_rem_in;
   logic [32:0]        div_num_ff, div_num_in;
   logic [5:0]         div_cnt_ff, div_cnt_in;
   logic               div_axis_ff, div_axis_in;
   logic signed [39:0] hx_ff, hx_in, hy_ff, hy_in, hy0_ff, hy0_in;
   logic signed [35:0] xi_ff, xi_in, yi_ff, yi_in, yi0_ff, yi0_in;
   logic [3:0]         jx_ff, jx_in, jy_ff, jy_in;
   logic [2:0]         set_cnt_ff, set_cnt_in;
   logic [63:0]        d_ff, d_in, lo_ff, lo_in, mul_ff;
   logic [15:0]        w_ff, w_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               rd_inside_ff, rd_inside_in;

   // Response register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_sum_ff, rsp_sum_in;
   logic [47:0]  rsp_wt_ff, rsp_wt_in;
   logic         rsp_cv_ff, rsp_cv_in;

   // Accumulator memories.
   logic [63:0] sum_mem [DEPTH];
   logic [47:0] wt_mem  [DEPTH];
   logic [63:0] sum_rd_ff;
   logic [47:0] wt_rd_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0] wr_sum;
   logic [47:0] wr_wt;

   // Shared multiplier.
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   // Helpers.
   logic [10:0]        ew, eh;
   logic [32:0]        div_t;
   logic               div_bit;
   logic [31:0]        div_rem_nx;
   logic [32:0]        div_q_fin;
   logic               div_neg;
   logic signed [35:0] div_cq;
   logic signed [33:0] div_srem;
   logic signed [39:0] div_h;
   logic signed [39:0] cs2;
   logic [39:0]        ax, ay;
   logic               in_grid, far;
   logic [63:0]        top;
   logic [34:0]        tprod;
   logic [TW-1:0]      tix;
   logic [63:0]        sum_nx;
   logic               sum_ovf;
   logic [48:0]        wt_nx;
   logic               adv;
   logic [3:0]         span;
   logic               req_acc;
   logic [32:0]        pdx, pdy;
   logic [31:0]        cs_eff;
   logic [2:0]         r_eff;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_wt_ff, rsp_sum_ff};
   assign rsp_tuser  = rsp_cv_ff;

   // Effective grid size, cell size and radius.
   assign ew     = (11'(gw_ff) > 11'(GRID_W)) ? 11'(GRID_W) : 11'(gw_ff);
   assign eh     = (11'(gh_ff) > 11'(GRID_H)) ? 11'(GRID_H) : 11'(gh_ff);
   assign cs_eff = (cell_size_ff == 32'd0) ? 32'd1 : cell_size_ff;
   assign r_eff  = (4'(radius_ff) > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_ff;
   assign pdx    = {1'b0, req_tdata[31:0]} - {1'b0, org_x_ff};
   assign pdy    = {1'b0, req_tdata[63:32]} - {1'b0, org_y_ff};

   // One restoring division step and the signed home cell it gives.
   assign div_t      = {div_rem_ff, div_num_ff[32]};
   assign div_bit    = (div_t >= {1'b0, cs_ff});
   assign div_rem_nx = div_bit ? 32'(div_t - {1'b0, cs_ff}) : div_t[31:0];
   assign div_q_fin  = {div_num_ff[31:0], div_bit};
   assign div_neg    = div_axis_ff ? dy_ff[32] : dx_ff[32];
   assign div_cq     = div_neg ? -$signed({3'b0, div_q_fin}) : $signed({3'b0, div_q_fin});
   assign div_srem   = div_neg ? -$signed({2'b0, div_rem_nx}) : $signed({2'b0, div_rem_nx});
   assign div_h      = (40'(div_srem) <<< 1) - $signed({8'b0, cs_ff});
   assign cs2        = $signed({7'b0, cs_ff, 1'b0});

   // Cell position checks.
   assign ax      = hx_ff[39] ? 40'(-hx_ff) : 40'(hx_ff);
   assign ay      = hy_ff[39] ? 40'(-hy_ff) : 40'(hy_ff);
   assign far     = (ax[39:30] != 10'd0) || (ay[39:30] != 10'd0);
   assign in_grid = !xi_ff[35] && (xi_ff < $signed({25'b0, ew}))
                    && !yi_ff[35] && (yi_ff < $signed({25'b0, eh}));
   assign span    = {r_ff, 1'b0};

   // Exponent and table index.
   assign top   = mul_ff + (lo_ff >> 32);
   assign tprod = 35'(top[21:0]) * 35'(WEIGHT_TABLE);
   assign tix   = tprod[22 +: TW];

   // Saturating accumulation.
   assign sum_nx  = sum_rd_ff + mul_ff;
   assign sum_ovf = (sum_rd_ff[63] == mul_ff[63]) && (sum_nx[63] != sum_rd_ff[63]);
   assign wt_nx   = {1'b0, wt_rd_ff} + 49'(w_ff);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_CELL: begin
            mul_a = $signed({3'b0, ax[29:0]});
            mul_b = $signed({3'b0, ax[29:0]});
         end
         S_M1: begin
            mul_a = $signed({3'b0, ay[29:0]});
            mul_b = $signed({3'b0, ay[29:0]});
         end
         S_M3: begin
            mul_a = $signed({1'b0, d_ff[31:0]});
            mul_b = $signed({1'b0, inv_ff});
         end
         S_M4: begin
            mul_a = $signed({1'b0, d_ff[63:32]});
            mul_b = $signed({1'b0, inv_ff});
         end
         S_RD: begin
            mul_a = $signed({val_ff[31], val_ff});
            mul_b = $signed({17'b0, w_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      val_in       = val_ff;
      cs_in        = cs_ff;
      r_in         = r_ff;
      div_rem_in   = div_rem_ff;
      div_num_in   = div_num_ff;
      div_cnt_in   = div_cnt_ff;
      div_axis_in  = div_axis_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      hy0_in       = hy0_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      yi0_in       = yi0_ff;
      jx_in        = jx_ff;
      jy_in        = jy_ff;
      set_cnt_in   = set_cnt_ff;
      d_in         = d_ff;
      lo_in        = lo_ff;
      w_in         = w_ff;
      idx_in       = idx_ff;
      rd_inside_in = rd_inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_cv_in    = rsp_cv_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_sum       = '0;
      wr_wt        = '0;
      adv          = 1'b0;

      case (state_ff)
         S_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == CMD_READ) begin
                  rd_inside_in = (11'(req_tdata[103:96]) < ew)
                                 && (11'(req_tdata[111:104]) < eh);
                  idx_in   = AW'(32'(req_tdata[111:104]) * 32'(GRID_W)
                                 + 32'(req_tdata[103:96]));
                  state_in = S_RQ;
               end else begin
                  dx_in       = $signed(pdx);
                  dy_in       = $signed(pdy);
                  val_in      = $signed(req_tdata[95:64]);
                  cs_in       = cs_eff;
                  r_in        = r_eff;
                  div_rem_in  = '0;
                  div_num_in  = pdx[32] ? 33'(-pdx) : pdx;
                  div_cnt_in  = '0;
                  div_axis_in = 1'b0;
                  state_in    = S_DIV;
               end
            end
         end
         S_RQ: begin
            state_in = S_RO;
         end
         S_RO: begin
            // Wait for the previous response to be taken.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = rd_inside_ff ? sum_rd_ff : 64'd0;
               rsp_wt_in    = rd_inside_ff ? wt_rd_ff : 48'd0;
               rsp_cv_in    = rd_inside_ff;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            div_rem_in = div_rem_nx;
            div_num_in = div_q_fin;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd32) begin
               if (!div_axis_ff) begin
                  hx_in       = div_h;
                  xi_in       = div_cq - 36'(r_ff);
                  div_rem_in  = '0;
                  div_num_in  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
                  div_cnt_in  = '0;
                  div_axis_in = 1'b1;
               end else begin
                  hy_in      = div_h;
                  yi_in      = div_cq - 36'(r_ff);
                  yi0_in     = div_cq - 36'(r_ff);
                  set_cnt_in = '0;
                  jx_in      = '0;
                  jy_in      = '0;
                  state_in   = S_SET;
               end
            end
         end
         S_SET: begin
            // Move both doubled offsets to the lowest neighbor row and column.
            if (set_cnt_ff == r_ff) begin
               hy0_in   = hy_ff;
               state_in = S_CELL;
            end else begin
               hx_in      = hx_ff + cs2;
               hy_in      = hy_ff + cs2;
               set_cnt_in = set_cnt_ff + 3'd1;
            end
         end
         S_CELL: begin
            idx_in = AW'(32'(yi_ff[9:0]) * 32'(GRID_W) + 32'(xi_ff[9:0]));
            if (!in_grid) begin
               adv = 1'b1;
            end else if (inv_ff == 32'd0) begin
               w_in     = WTAB[0];
               state_in = S_RD;
            end else if (far) begin
               adv = 1'b1;
            end else begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            d_in     = mul_ff;
            state_in = S_M2;
         end
         S_M2: begin
            d_in     = d_ff + mul_ff;
            state_in = S_M3;
         end
         S_M3: begin
            state_in = S_M4;
         end
         S_M4: begin
            lo_in    = mul_ff;
            state_in = S_M5;
         end
         S_M5: begin
            if (top >= (64'd16 << 18)) begin
               adv = 1'b1;
            end else begin
               w_in     = WTAB[tix];
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (w_ff == 16'd0) begin
               adv = 1'b1;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            wr_en  = 1'b1;
            wr_sum = sum_ovf ? (sum_rd_ff[63] ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF) : sum_nx;
            wr_wt  = wt_nx[48] ? 48'hFFFF_FFFF_FFFF : wt_nx[47:0];
            adv    = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Step to the next neighborhood cell, rows inside columns.
      if (adv) begin
         state_in = S_CELL;
         if (jy_ff == span) begin
            jy_in = '0;
            yi_in = yi0_ff;
            hy_in = hy0_ff;
            if (jx_ff == span) begin
               state_in = S_IDLE;
            end else begin
               jx_in = jx_ff + 4'd1;
               xi_in = xi_ff + 36'sd1;
               hx_in = hx_ff - cs2;
            end
         end else begin
            jy_in = jy_ff + 4'd1;
            yi_in = yi_ff + 36'sd1;
            hy_in = hy_ff - cs2;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         cell_size_ff <= RST_CELL_SIZE;
         radius_ff    <= RST_RADIUS;
         inv_ff       <= RST_INV_CUT;
         gw_ff        <= RST_GRID_DIM;
         gh_ff        <= RST_GRID_DIM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ORIGIN_X:      org_x_ff     <= csr_data;
            REG_ORIGIN_Y:      org_y_ff     <= csr_data;
            REG_CELL_SIZE:     cell_size_ff <= csr_data;
            REG_RADIUS_CELLS:  radius_ff    <= csr_data[2:0];
            REG_INV_CUTOFF_SQ: inv_ff       <= csr_data;
            REG_GRID_WIDTH:    gw_ff        <= csr_data[8:0];
            REG_GRID_HEIGHT:   gh_ff        <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      val_ff       <= val_in;
      cs_ff        <= cs_in;
      r_ff         <= r_in;
      div_rem_ff   <= div_rem_in;
      div_num_ff   <= div_num_in;
      div_cnt_ff   <= div_cnt_in;
      div_axis_ff  <= div_axis_in;
      hx_ff        <= hx_in;
      hy_ff        <= hy_in;
      hy0_ff       <= hy0_in;
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      yi0_ff       <= yi0_in;
      jx_ff        <= jx_in;
      jy_ff        <= jy_in;
      set_cnt_ff   <= set_cnt_in;
      d_ff         <= d_in;
      lo_ff        <= lo_in;
      w_ff         <= w_in;
      idx_ff       <= idx_in;
      rd_inside_ff <= rd_inside_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_wt_ff    <= rsp_wt_in;
      rsp_cv_ff    <= rsp_cv_in;
      mul_ff       <= mul_p[63:0];
   end

   // Accumulator memories, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr] <= wr_sum;
         wt_mem[wr_addr]  <= wr_wt;
      end
      sum_rd_ff <= sum_mem[idx_ff];
      wt_rd_ff  <= wt_mem[idx_ff];
   end

   // Requests are taken only by an idle sequencer.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE))
      else $error("request ready outside idle");

   // A memory update follows its read cycle.
   a_acc_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> ($past(state_ff) == S_RD))
      else $error("accumulate without a preceding read");

   // Only a nonzero weight reaches the accumulate step.
   a_acc_weight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (w_ff != 16'd0))
      else $error("accumulate with zero weight");

   // A new response comes only from the read output step.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_RO))
      else $error("response raised outside read output");

   // The divider never runs past its last quotient bit.
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff <= 6'd32))
      else $error("divider count out of range");

endmodule
